// ===== design/lbs_pkg.sv =====
// Package for the linear blend skinning block: opcodes, controller states,
// command and status structs and Q16.16 helpers. No dependencies.
package lbs_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_INFL  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFF_RD,
    ST_OFF_MAC,
    ST_ANI_RD,
    ST_ANI_MAC,
    ST_WEIGHT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       latch_item;
    logic       pal_write;
    logic       start_vertex;
    logic       rd_off;
    logic       rd_ani;
    logic [3:0] elem;
    logic       mac_off;
    logic       mac_ani;
    logic       row_done_off;
    logic       row_done_ani;
    logic       do_weight;
    logic       set_error;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t     opcode;
    logic        last;
    logic        id_none;
    logic        id_bad;
    logic        pal_ok;
    logic        out_busy;
  } dp_status_t;

  function automatic logic signed [63:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ===== design/lbs_datapath.sv =====
// Datapath for linear blend skinning: palette memories, one shared 32x32
// multiplier with accumulator, vertex state and output register.
// Depends on lbs_pkg.
module lbs_datapath #(
  parameter int NUM_BONES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          cfg_bone_count,
  input  logic [1:0]          in_opcode,
  input  logic                in_msel,
  input  logic signed [8:0]   in_bone_id,
  input  logic [3:0]          in_element,
  input  logic signed [31:0]  in_value,
  input  logic signed [31:0]  in_px,
  input  logic signed [31:0]  in_py,
  input  logic signed [31:0]  in_pz,
  input  logic                in_last,
  input  lbs_pkg::dp_cmd_t    cmd,
  output lbs_pkg::dp_status_t status,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [96:0]         out_payload
);
  import lbs_pkg::*;

  localparam int AW = $clog2(NUM_BONES * 16);
  localparam int BW = $clog2(NUM_BONES) > 0 ? $clog2(NUM_BONES) : 1;

  logic signed [31:0] ani_mem [NUM_BONES*16];
  logic signed [31:0] off_mem [NUM_BONES*16];

  logic [1:0]          op_r;
  logic                msel_r, last_r;
  logic signed [8:0]   id_r;
  logic [3:0]          elem_r;
  logic signed [31:0]  val_r, px_r, py_r, pz_r;
  logic signed [31:0]  pos_r [3];
  logic signed [31:0]  acc_r [3];
  logic signed [31:0]  q_r [4];
  logic signed [31:0]  r_r [3];
  logic signed [31:0]  rd_r;
  logic signed [63:0]  sum_r;
  logic                err_r;
  logic                ov_r;
  logic [96:0]         od_r;
  logic [AW-1:0]       addr;
  logic [BW-1:0]       bone;
  logic signed [31:0]  mul_a;
  logic [1:0]          wi;
  logic signed [31:0]  mul_b;
  logic signed [63:0]  prod;
  logic                id_in_nb;
  logic signed [31:0]  wadd;
  logic signed [31:0]  acc_fin [3];
  logic                err_fin;

  assign id_in_nb = (id_r >= 0) && (int'(id_r) < NUM_BONES);
  assign bone = id_r[BW-1:0];
  assign addr = AW'({bone, cmd.elem});

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      op_r <= in_opcode; msel_r <= in_msel; id_r <= in_bone_id;
      elem_r <= in_element; val_r <= in_value; last_r <= in_last;
      px_r <= in_px; py_r <= in_py; pz_r <= in_pz;
    end
    if (cmd.pal_write && id_in_nb) begin
      if (msel_r) off_mem[AW'({bone, elem_r})] <= val_r;
      else ani_mem[AW'({bone, elem_r})] <= val_r;
    end
    if (cmd.rd_off) rd_r <= off_mem[addr];
    else if (cmd.rd_ani) rd_r <= ani_mem[addr];
  end

  assign wi = cmd.elem[1:0];
  assign mul_a = cmd.do_weight ? val_r : rd_r;

  always_comb begin
    if (cmd.do_weight) mul_b = r_r[wi];
    else begin
      case (cmd.elem[1:0])
        2'd0: mul_b = cmd.mac_off ? pos_r[0] : q_r[0];
        2'd1: mul_b = cmd.mac_off ? pos_r[1] : q_r[1];
        2'd2: mul_b = cmd.mac_off ? pos_r[2] : q_r[2];
        default: mul_b = q_r[3];
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  logic signed [63:0] term;
  logic signed [63:0] sum_nxt;
  always_comb begin
    if (cmd.mac_off && cmd.elem[1:0] == 2'd3) term = 64'(rd_r);
    else term = qround(prod);
    sum_nxt = sum_r + term;
  end

  // result as it stands after this cycle's start, error flag and weighted add
  always_comb begin
    wadd = sat32(64'(acc_r[wi]) + 64'(sat32(qround(prod))));
    for (int i = 0; i < 3; i++) begin
      if (cmd.start_vertex) acc_fin[i] = '0;
      else if (cmd.do_weight && int'(wi) == i) acc_fin[i] = wadd;
      else acc_fin[i] = acc_r[i];
    end
    err_fin = !cmd.start_vertex && (err_r || cmd.set_error);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0; ov_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin pos_r[i] <= '0; acc_r[i] <= '0; end
      sum_r <= '0;
    end else begin
      if (cmd.start_vertex) begin
        pos_r[0] <= px_r; pos_r[1] <= py_r; pos_r[2] <= pz_r;
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
        err_r <= 1'b0;
      end
      if (cmd.set_error) err_r <= 1'b1;
      if (cmd.mac_off || cmd.mac_ani) begin
        if (cmd.row_done_off) begin
          q_r[cmd.elem[3:2]] <= sat32(sum_nxt); sum_r <= '0;
        end else if (cmd.row_done_ani) begin
          r_r[cmd.elem[3:2]] <= sat32(sum_nxt); sum_r <= '0;
        end else sum_r <= sum_nxt;
      end
      if (cmd.do_weight)
        acc_r[wi] <= wadd;
      if (cmd.emit) begin
        ov_r <= 1'b1;
        od_r <= {err_fin, acc_fin[2], acc_fin[1], acc_fin[0]};
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
        err_r <= 1'b0;
      end else if (out_tready) ov_r <= 1'b0;
    end
  end

  assign status.opcode = opcode_t'(op_r);
  assign status.last = last_r;
  assign status.id_none = (id_r == -9'sd1);
  assign status.id_bad = (id_r < 0) || ({1'b0, id_r[7:0]} >= {2'b0, cfg_bone_count})
                         || !id_in_nb;
  assign status.pal_ok = id_in_nb;
  assign status.out_busy = ov_r && !out_tready;
  assign out_tvalid = ov_r;
  assign out_payload = od_r;
endmodule

// ===== design/lbs_ctrl.sv =====
// Controller for linear blend skinning: sequences item decode, offset and
// animated matrix passes and the weighted add. Depends on lbs_pkg.
module lbs_ctrl #(
  parameter int MAX_INFLUENCES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lbs_pkg::dp_status_t status,
  output lbs_pkg::dp_cmd_t    cmd
);
  import lbs_pkg::*;

  localparam int CW = $clog2(MAX_INFLUENCES + 1);

  state_t        state_r, state_nxt;
  logic [3:0]    el_r, el_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; el_r <= '0; cnt_r <= '0;
    end else begin
      state_r <= state_nxt; el_r <= el_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r; el_nxt = el_r; cnt_nxt = cnt_r;
    cmd = '0;
    cmd.elem = el_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch_item = in_tvalid;
        if (in_tvalid) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
          case (status.opcode)
            OP_WRITE: cmd.pal_write = 1'b1;
            OP_START: begin
              cmd.start_vertex = 1'b1; cnt_nxt = '0;
              if (status.last) begin cmd.emit = 1'b1; end
            end
            OP_INFL: begin
              if (cnt_r < CW'(MAX_INFLUENCES)) begin
                cnt_nxt = cnt_r + 1'b1;
                if (status.id_none) begin
                  if (status.last) begin cmd.emit = 1'b1; cnt_nxt = '0; end
                end else if (status.id_bad) begin
                  cmd.set_error = 1'b1;
                  if (status.last) begin cmd.emit = 1'b1; cnt_nxt = '0; end
                end else begin
                  el_nxt = '0; state_nxt = ST_OFF_RD;
                end
              end else if (status.last) begin
                cmd.emit = 1'b1; cnt_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_OFF_RD: begin cmd.rd_off = 1'b1; state_nxt = ST_OFF_MAC; end
      ST_OFF_MAC: begin
        cmd.mac_off = 1'b1;
        cmd.row_done_off = (el_r[1:0] == 2'd3);
        el_nxt = el_r + 1'b1;
        if (el_r == 4'd15) begin el_nxt = '0; state_nxt = ST_ANI_RD; end
        else state_nxt = ST_OFF_RD;
      end
      ST_ANI_RD: begin cmd.rd_ani = 1'b1; state_nxt = ST_ANI_MAC; end
      ST_ANI_MAC: begin
        cmd.mac_ani = 1'b1;
        cmd.row_done_ani = (el_r[1:0] == 2'd3);
        el_nxt = el_r + 1'b1;
        if (el_r == 4'd11) begin el_nxt = '0; state_nxt = ST_WEIGHT; end
        else state_nxt = ST_ANI_RD;
      end
      ST_WEIGHT: begin
        cmd.do_weight = 1'b1;
        el_nxt = el_r + 1'b1;
        if (el_r == 4'd2) begin
          el_nxt = '0;
          if (!status.last) state_nxt = ST_IDLE;
          else if (!status.out_busy) begin
            cmd.emit = 1'b1; cnt_nxt = '0; state_nxt = ST_IDLE;
          end else begin
            el_nxt = el_r; cmd.do_weight = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== design/linear_blend_vertex_skinning.sv =====
// Linear blend skinning, Q16.16, up to MAX_INFLUENCES bones per vertex.
// One item is taken at a time. An influence makes 16 offset and 12 animated
// reads of the palette memory port, each read followed by one step of the
// single shared multiplier, then 3 weighted adds. The result register lets
// the next item in while a result waits. Palette entries read before
// written are undefined.
module linear_blend_vertex_skinning #(
  parameter int NUM_BONES      = 64,
  parameter int MAX_INFLUENCES = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode, matrix_select, bone_id, element, value, pos_x, pos_y, pos_z
  input  logic [143:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z
  output logic [95:0]  out_tdata,
  // range_error
  output logic         out_tuser
);
  import lbs_pkg::*;

  logic [6:0]  bone_count_r;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [96:0] payload;

  always_ff @(posedge clk) begin
    if (!rst_n) bone_count_r <= '0;
    else if (cfg_we) bone_count_r <= cfg_wdata;
  end

  lbs_ctrl #(.MAX_INFLUENCES(MAX_INFLUENCES)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .status, .cmd
  );

  lbs_datapath #(.NUM_BONES(NUM_BONES)) u_dp (
    .clk, .rst_n,
    .cfg_bone_count(bone_count_r),
    .in_opcode(in_tdata[1:0]),
    .in_msel(in_tdata[2]),
    .in_bone_id(in_tdata[11:3]),
    .in_element(in_tdata[15:12]),
    .in_value(in_tdata[47:16]),
    .in_px(in_tdata[79:48]),
    .in_py(in_tdata[111:80]),
    .in_pz(in_tdata[143:112]),
    .in_last(in_tlast),
    .cmd, .status,
    .out_tvalid, .out_tready,
    .out_payload(payload)
  );

  assign out_tdata = payload[95:0];
  assign out_tuser = payload[96];
endmodule
